// ===== rtl/msp_pkg.sv =====
// Shared constants, types and state codes for the multi-track sample player.
// No dependencies; used by msp_rem and the top module in rtl/.
package msp_pkg;

    localparam int TRACKS      = 8;
    localparam int SLOTS       = 8;
    localparam int SLOT_LEN    = 8192;

    localparam int TRK_W       = 3;
    localparam int SLOT_W      = 3;
    localparam int IDX_W       = 13;
    localparam int LEN_W       = 14;
    localparam int SMP_W       = 16;
    localparam int RATE_W      = 20;
    localparam int LEVEL_W     = 16;
    localparam int FRAC_W      = 16;
    localparam int POS_W       = 30;
    localparam int IPOS_W      = POS_W - FRAC_W;
    localparam int PROD_W      = SMP_W + LEVEL_W + 1;
    localparam int ACC_W       = PROD_W + TRK_W;
    localparam int MEM_DEPTH   = SLOTS * SLOT_LEN;
    localparam int MEM_AW      = SLOT_W + IDX_W;
    localparam int REM_CNT_W   = $clog2(IPOS_W + 1);

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;

    localparam logic [ACC_W-1:0]   SOUND_FLOOR = ACC_W'(107);
    localparam logic [ACC_W-1:0]   ROUND_HALF  = ACC_W'(16384);
    localparam logic [LEVEL_W-1:0] LEVEL_UNITY = LEVEL_W'(32768);

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_START = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_RMOD,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_PMOD,
        ST_NEXT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [IPOS_W-1:0] dividend;
        logic [LEN_W-1:0]  divisor;
    } t_rem_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [LEN_W-1:0]  rem;
    } t_rem_rsp;

    typedef struct packed {
        logic rem_start_rd;
        logic rem_start_pos;
        logic ld_ipos_direct;
        logic ld_ipos_rem;
        logic ram_re;
        logic ld_mul;
        logic ld_acc;
        logic ld_pos_direct;
        logic ld_pos_rem;
        logic trk_inc;
        logic tick_init;
        logic out_load;
    } t_ctl;

endpackage

// ===== rtl/msp_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module msp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/msp_rem.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on msp_pkg (widths, request and response structs).
module msp_rem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msp_pkg::t_rem_req i_req,
    output msp_pkg::t_rem_rsp o_rsp
);

    logic [msp_pkg::LEN_W-1:0]     r_rem;
    logic [msp_pkg::IPOS_W-1:0]    r_dvd;
    logic [msp_pkg::LEN_W-1:0]     r_div;
    logic [msp_pkg::REM_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [msp_pkg::LEN_W:0]       trial;
    logic [msp_pkg::LEN_W:0]       diff;

    assign trial = {r_rem, r_dvd[msp_pkg::IPOS_W-1]};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= msp_pkg::REM_CNT_W'(msp_pkg::IPOS_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == msp_pkg::REM_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[msp_pkg::IPOS_W-2:0], 1'b0};
            if (!diff[msp_pkg::LEN_W]) begin
                r_rem <= diff[msp_pkg::LEN_W-1:0];
            end else begin
                r_rem <= trial[msp_pkg::LEN_W-1:0];
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_div != '0 |-> r_rem < r_div)
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a preceding busy cycle");

endmodule

// ===== rtl/multi_track_sample_player_top.sv =====
// Multi-track sample player: slot memory, track state and the mixing sequencer.
// Depends on msp_pkg, msp_ram (sample memory) and msp_rem (shared remainder unit).
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata, tuser = action, tlast = write_last
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata = mix_sample, sound, finished_mask
//
// Write and start items give no result; a tick gives one result.
// A tick visits every track in turn; an active looping track takes two passes of the shared remainder unit.
// Reset is synchronous, active low; it clears slot lengths and track state (level goes to unity), not samples.
// Input is not taken while a tick runs; a finished tick waits in its last cycle until
// the output register is free, and no item is taken meanwhile.
module multi_track_sample_player_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // slot[2:0] index[15:3] sample_value[31:16] track[34:32] rate[54:35]
    // level[70:55] loop_on[71]
    input  logic [msp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action[1:0]
    input  logic [1:0]                         s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // mix_sample[15:0] sound[16] finished_mask[24:17] zero[31:25]
    output logic [msp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic [msp_pkg::SLOT_W-1:0]  in_slot;
    logic [msp_pkg::IDX_W-1:0]   in_index;
    logic [msp_pkg::SMP_W-1:0]   in_value;
    logic [msp_pkg::TRK_W-1:0]   in_track;
    logic [msp_pkg::RATE_W-1:0]  in_rate;
    logic [msp_pkg::LEVEL_W-1:0] in_level;
    logic                        in_loop;
    logic                        in_acc;

    assign in_slot  = s_axis_tdata[2:0];
    assign in_index = s_axis_tdata[15:3];
    assign in_value = s_axis_tdata[31:16];
    assign in_track = s_axis_tdata[34:32];
    assign in_rate  = s_axis_tdata[54:35];
    assign in_level = s_axis_tdata[70:55];
    assign in_loop  = s_axis_tdata[71];
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    logic [msp_pkg::LEN_W-1:0]   r_slen  [msp_pkg::SLOTS];
    logic [msp_pkg::SLOT_W-1:0]  r_tslot [msp_pkg::TRACKS];
    logic [msp_pkg::POS_W-1:0]   r_tpos  [msp_pkg::TRACKS];
    logic [msp_pkg::RATE_W-1:0]  r_trate [msp_pkg::TRACKS];
    logic [msp_pkg::LEVEL_W-1:0] r_tlvl  [msp_pkg::TRACKS];
    logic                        r_tloop [msp_pkg::TRACKS];

    msp_pkg::t_state             r_state, n_state;
    msp_pkg::t_ctl               ctl;
    logic [msp_pkg::TRK_W-1:0]   r_trk;
    logic [msp_pkg::IPOS_W-1:0]  r_ipos;
    logic                        r_hit;
    logic signed [msp_pkg::PROD_W-1:0] r_prod;
    logic [msp_pkg::POS_W-1:0]   r_newpos;
    logic signed [msp_pkg::ACC_W-1:0]  r_acc;
    logic                        r_sound;
    logic [msp_pkg::TRACKS-1:0]  r_fin;
    logic                        r_out_valid;
    logic [msp_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [msp_pkg::SLOT_W-1:0]  cur_slot;
    logic [msp_pkg::LEN_W-1:0]   cur_len;
    logic                        cur_active;
    logic                        cur_loop_mod;
    logic [msp_pkg::POS_W-1:0]   cur_span;
    logic signed [msp_pkg::ACC_W-1:0] n_acc;
    logic signed [msp_pkg::ACC_W-1:0] rnd;
    logic signed [msp_pkg::ACC_W-msp_pkg::FRAC_W+1-1:0] rnd_q;
    logic [msp_pkg::SMP_W-1:0]   mix_sat;
    logic [msp_pkg::SMP_W-1:0]   ram_rdata;
    logic signed [msp_pkg::SMP_W-1:0] word;
    logic                        out_free;

    msp_pkg::t_rem_req rem_req;
    msp_pkg::t_rem_rsp rem_rsp;

    assign cur_slot     = r_tslot[r_trk];
    assign cur_len      = r_slen[cur_slot];
    assign cur_active   = (r_trate[r_trk] != '0) && (r_tlvl[r_trk] != '0);
    assign cur_loop_mod = r_tloop[r_trk] && (cur_len != '0);
    assign cur_span     = {cur_len, {msp_pkg::FRAC_W{1'b0}}};
    assign n_acc        = r_acc + msp_pkg::ACC_W'(r_prod);
    assign out_free     = !r_out_valid || m_axis_tready;

    assign rem_req.start    = ctl.rem_start_rd || ctl.rem_start_pos;
    assign rem_req.dividend = ctl.rem_start_pos ? r_newpos[msp_pkg::POS_W-1:msp_pkg::FRAC_W]
                                                : r_tpos[r_trk][msp_pkg::POS_W-1:msp_pkg::FRAC_W];
    assign rem_req.divisor  = cur_len;

    msp_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    msp_ram #(
        .WIDTH (msp_pkg::SMP_W),
        .DEPTH (msp_pkg::MEM_DEPTH)
    ) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && s_axis_tuser == msp_pkg::ACT_WRITE),
        .i_waddr ({in_slot, in_index}),
        .i_wdata (in_value),
        .i_re    (ctl.ram_re),
        .i_raddr ({cur_slot, r_ipos[msp_pkg::IDX_W-1:0]}),
        .o_rdata (ram_rdata)
    );

    assign word = r_hit ? $signed(ram_rdata) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            msp_pkg::ST_IDLE: begin
                if (in_acc && s_axis_tuser == msp_pkg::ACT_TICK) begin
                    n_state = msp_pkg::ST_CHK;
                end
            end
            msp_pkg::ST_CHK: begin
                if (!cur_active) begin
                    n_state = msp_pkg::ST_NEXT;
                end else if (cur_loop_mod) begin
                    n_state = msp_pkg::ST_RMOD;
                end else begin
                    n_state = msp_pkg::ST_RD;
                end
            end
            msp_pkg::ST_RMOD: begin
                if (rem_rsp.done) begin
                    n_state = msp_pkg::ST_RD;
                end
            end
            msp_pkg::ST_RD:  n_state = msp_pkg::ST_MUL;
            msp_pkg::ST_MUL: n_state = msp_pkg::ST_ACC;
            msp_pkg::ST_ACC: begin
                n_state = cur_loop_mod ? msp_pkg::ST_PMOD : msp_pkg::ST_NEXT;
            end
            msp_pkg::ST_PMOD: begin
                if (rem_rsp.done) begin
                    n_state = msp_pkg::ST_NEXT;
                end
            end
            msp_pkg::ST_NEXT: begin
                if (r_trk == msp_pkg::TRK_W'(msp_pkg::TRACKS - 1)) begin
                    n_state = msp_pkg::ST_OUT;
                end else begin
                    n_state = msp_pkg::ST_CHK;
                end
            end
            msp_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = msp_pkg::ST_IDLE;
                end
            end
            default: n_state = msp_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctl = '0;
        case (r_state)
            msp_pkg::ST_IDLE: begin
                ctl.tick_init = in_acc && s_axis_tuser == msp_pkg::ACT_TICK;
            end
            msp_pkg::ST_CHK: begin
                ctl.rem_start_rd   = cur_active && cur_loop_mod;
                ctl.ld_ipos_direct = cur_active && !cur_loop_mod;
            end
            msp_pkg::ST_RMOD: ctl.ld_ipos_rem = rem_rsp.done;
            msp_pkg::ST_RD:   ctl.ram_re = 1'b1;
            msp_pkg::ST_MUL:  ctl.ld_mul = 1'b1;
            msp_pkg::ST_ACC: begin
                ctl.ld_acc        = 1'b1;
                ctl.rem_start_pos = cur_loop_mod;
                ctl.ld_pos_direct = !cur_loop_mod;
            end
            msp_pkg::ST_PMOD: ctl.ld_pos_rem = rem_rsp.done;
            msp_pkg::ST_NEXT: ctl.trk_inc = r_trk != msp_pkg::TRK_W'(msp_pkg::TRACKS - 1);
            msp_pkg::ST_OUT:  ctl.out_load = out_free;
            default: ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // slot lengths and track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < msp_pkg::SLOTS; s++) begin
                r_slen[s] <= '0;
            end
            for (int t = 0; t < msp_pkg::TRACKS; t++) begin
                r_tslot[t] <= '0;
                r_tpos[t]  <= '0;
                r_trate[t] <= '0;
                r_tlvl[t]  <= msp_pkg::LEVEL_UNITY;
                r_tloop[t] <= 1'b0;
            end
        end else begin
            if (in_acc && s_axis_tuser == msp_pkg::ACT_WRITE && s_axis_tlast) begin
                r_slen[in_slot] <= msp_pkg::LEN_W'(in_index) + 1'b1;
            end
            if (in_acc && s_axis_tuser == msp_pkg::ACT_START && r_slen[in_slot] != '0) begin
                r_tslot[in_track] <= in_slot;
                r_trate[in_track] <= in_rate;
                r_tlvl[in_track]  <= in_level;
                r_tloop[in_track] <= in_loop;
                r_tpos[in_track]  <= '0;
            end
            if (ctl.ld_pos_direct) begin
                r_tpos[r_trk] <= r_newpos;
                if (!r_tloop[r_trk] && r_newpos > cur_span) begin
                    r_trate[r_trk] <= '0;
                end
            end
            if (ctl.ld_pos_rem) begin
                r_tpos[r_trk] <= {rem_rsp.rem, r_newpos[msp_pkg::FRAC_W-1:0]};
            end
        end
    end

    // tick datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk   <= '0;
            r_acc   <= '0;
            r_sound <= 1'b0;
            r_fin   <= '0;
        end else begin
            if (ctl.tick_init) begin
                r_trk   <= '0;
                r_acc   <= '0;
                r_sound <= 1'b0;
                r_fin   <= '0;
            end
            if (ctl.trk_inc) begin
                r_trk <= r_trk + 1'b1;
            end
            if (ctl.ld_acc) begin
                r_acc <= n_acc;
                if (n_acc > $signed(msp_pkg::SOUND_FLOOR)) begin
                    r_sound <= 1'b1;
                end
            end
            if (ctl.ld_pos_direct && !r_tloop[r_trk] && r_newpos > cur_span) begin
                r_fin[r_trk] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld_ipos_direct) begin
            r_ipos <= r_tpos[r_trk][msp_pkg::POS_W-1:msp_pkg::FRAC_W];
        end else if (ctl.ld_ipos_rem) begin
            r_ipos <= rem_rsp.rem;
        end
        if (ctl.ram_re) begin
            r_hit <= (cur_len != '0) && (r_ipos < cur_len);
        end
        if (ctl.ld_mul) begin
            r_prod   <= msp_pkg::PROD_W'(word)
                      * msp_pkg::PROD_W'($signed({1'b0, r_tlvl[r_trk]}));
            r_newpos <= r_tpos[r_trk] + msp_pkg::POS_W'(r_trate[r_trk]);
        end
    end

    // round half up, then saturate
    assign rnd   = r_acc + $signed(msp_pkg::ROUND_HALF);
    assign rnd_q = rnd[msp_pkg::ACC_W-1:msp_pkg::FRAC_W-1];

    always_comb begin
        if (rnd_q > 21'sd32767) begin
            mix_sat = 16'h7FFF;
        end else if (rnd_q < -21'sd32768) begin
            mix_sat = 16'h8000;
        end else begin
            mix_sat = rnd_q[msp_pkg::SMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_out_data <= {7'd0, r_fin, r_sound, mix_sat};
        end
    end

    assign s_axis_tready = (r_state == msp_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser == msp_pkg::ACT_TICK |=> r_state == msp_pkg::ST_CHK && r_trk == '0)
        else $error("tick did not start at the first track");

    a_rem_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msp_pkg::ST_RMOD || r_state == msp_pkg::ST_PMOD)
            |-> rem_rsp.busy || rem_rsp.done)
        else $error("waiting on idle remainder unit");

    a_loop_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ld_pos_rem |=> r_tpos[r_trk] < cur_span)
        else $error("looping position not reduced below span");

    a_out_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |-> r_state == msp_pkg::ST_OUT && !$past(ctl.tick_init))
        else $error("result loaded outside the end of a tick");

endmodule
